/* hdl/tmrc_pkg.sv */
// Shared constants, types and helpers for the Turing machine run-and-count block.
`timescale 1ns / 1ps

package tmrc_pkg;

   // Tape and rule table sizes.
   localparam int TAPE_CELLS = 64;
   localparam int RULE_SLOTS = 8;

   // Derived widths.
   localparam int POS_W      = $clog2(TAPE_CELLS);
   localparam int RCNT_W     = $clog2(RULE_SLOTS + 1);
   localparam int CHUNK_BITS = 8;
   localparam int CHUNKS     = (TAPE_CELLS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int CHUNK_W    = $clog2(CHUNKS + 1);

   // Fixed field widths of the channels.
   localparam int RULE_W       = 8;
   localparam int RULE_FIELDS  = 8;
   localparam int RCOUNT_W     = 4;
   localparam int STATUS_W     = 2;
   localparam int ONES_W       = 7;
   localparam int STEPS_W      = 8;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;
   localparam int START_W      = 6;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CELL = 1'd1;

   // Configuration reset values.
   localparam logic [STEPS_W-1:0] STEP_LIMIT_RESET = 8'd128;
   localparam logic [START_W-1:0] START_CELL_RESET = 6'd31;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_HALTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OFFTAPE = 2'd2;

   // Next-state code that stops the machine.
   localparam logic [2:0] HALT_CODE = 3'd4;

   typedef logic [RULE_W-1:0] rule_type;
   typedef rule_type [RULE_SLOTS-1:0] rule_array_type;

   // Decoded action of the rule chosen for one transition.
   typedef struct packed {
      logic [2:0] next_code;
      logic       write_sym;
      logic       move_right;
   } rule_action_type;

   function automatic logic [3:0] popcount8(input logic [CHUNK_BITS-1:0] bits);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         n = n + 4'(bits[i]);
      end
      return n;
   endfunction

endpackage

/* hdl/tmrc_req_if.sv */
// Request channel carrying one candidate machine.
`timescale 1ns / 1ps

interface tmrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rule_0;
   logic [7:0] rule_1;
   logic [7:0] rule_2;
   logic [7:0] rule_3;
   logic [7:0] rule_4;
   logic [7:0] rule_5;
   logic [7:0] rule_6;
   logic [7:0] rule_7;
   logic [3:0] rule_count;

   modport source (
      output valid, rule_0, rule_1, rule_2, rule_3, rule_4, rule_5, rule_6, rule_7,
             rule_count,
      input  ready
   );

   modport sink (
      input  valid, rule_0, rule_1, rule_2, rule_3, rule_4, rule_5, rule_6, rule_7,
             rule_count,
      output ready
   );
endinterface

/* hdl/tmrc_rsp_if.sv */
// Response channel carrying the outcome of one run.
`timescale 1ns / 1ps

interface tmrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [6:0] ones_count;
   logic [7:0] steps_run;

   modport source (
      output valid, status, ones_count, steps_run,
      input  ready
   );

   modport sink (
      input  valid, status, ones_count, steps_run,
      output ready
   );
endinterface

/* hdl/turing_machine_run_and_count_top.sv */
// Top level: runs one candidate Turing machine on a blank tape and reports the outcome.
`timescale 1ns / 1ps

// Channel  Direction  Contents
// req      in         rule_0..rule_7 (8 b each), rule_count (4 b)
// rsp      out        status (2 b), ones_count (7 b), steps_run (8 b)
// csr      in         csr_write_en, csr_index (1 b), csr_write_data (8 b)
//
// One machine transition per cycle in the run loop, after a setup-free accept in idle;
// the result is then posted from the post state.
// A halted machine first passes through the count state for the ones count,
// which a shared 8-bit popcount adder works through one chunk a cycle.
// req.ready is high only while the sequencer is idle; a posted result waits in the
// rsp register while the next machine is taken. Reset is synchronous and active high.

module turing_machine_run_and_count_top (
   input  logic                                   clock,
   input  logic                                   reset,
   tmrc_req_if.sink                               req,
   tmrc_rsp_if.source                             rsp,
   input  logic                                   csr_write_en,
   input  logic [tmrc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tmrc_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_COUNT = 2'd2;
   localparam logic [1:0] S_POST  = 2'd3;

   localparam int TAPE_LAST = tmrc_pkg::TAPE_CELLS - 1;

   logic [1:0] ctl_ff, ctl_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [tmrc_pkg::STEPS_W-1:0] step_limit_ff, step_limit_in;
   logic [tmrc_pkg::START_W-1:0] start_cell_ff, start_cell_in;

   tmrc_pkg::rule_array_type     rules_ff, rules_in;
   logic [tmrc_pkg::RCNT_W-1:0]  nrules_ff, nrules_in;
   logic [tmrc_pkg::STEPS_W-1:0] limit_ff, limit_in;
   logic [tmrc_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]                   mach_ff, mach_in;
   logic [tmrc_pkg::STEPS_W-1:0] steps_ff, steps_in;
   logic [TAPE_LAST:0]           tape_ff, tape_in;
   logic [tmrc_pkg::ONES_W-1:0]  ones_ff, ones_in;
   logic [tmrc_pkg::CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [tmrc_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [tmrc_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [tmrc_pkg::ONES_W-1:0]   out_ones_ff, out_ones_in;
   logic [tmrc_pkg::STEPS_W-1:0]  out_steps_ff, out_steps_in;

   tmrc_pkg::rule_type [tmrc_pkg::RULE_FIELDS-1:0] req_rules;
   tmrc_pkg::rule_action_type action;
   logic [tmrc_pkg::STEPS_W-1:0] steps_next;
   logic offtape;

   assign req_rules = {req.rule_7, req.rule_6, req.rule_5, req.rule_4,
                       req.rule_3, req.rule_2, req.rule_1, req.rule_0};

   tmrc_rule_sel u_rule_sel (
      .rules      (rules_ff),
      .rule_count (nrules_ff),
      .mach_state (mach_ff),
      .read_sym   (tape_ff[pos_ff]),
      .action     (action)
   );

   assign steps_next = steps_ff + 8'd1;
   assign offtape    = action.move_right ? (pos_ff == tmrc_pkg::POS_W'(TAPE_LAST))
                                         : (pos_ff == '0);

   assign req.ready      = (ctl_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.ones_count = out_ones_ff;
   assign rsp.steps_run  = out_steps_ff;

   // Configuration writes.
   always_comb begin
      step_limit_in = step_limit_ff;
      start_cell_in = start_cell_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tmrc_pkg::CSR_STEP_LIMIT: step_limit_in = csr_write_data;
            tmrc_pkg::CSR_START_CELL: start_cell_in = csr_write_data[tmrc_pkg::START_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      ctl_in        = ctl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rules_in      = rules_ff;
      nrules_in     = nrules_ff;
      limit_in      = limit_ff;
      pos_in        = pos_ff;
      mach_in       = mach_ff;
      steps_in      = steps_ff;
      tape_in       = tape_ff;
      ones_in       = ones_ff;
      chunk_in      = chunk_ff;
      status_in     = status_ff;
      out_status_in = out_status_ff;
      out_ones_in   = out_ones_ff;
      out_steps_in  = out_steps_ff;

      unique case (ctl_ff)
         S_IDLE: begin
            if (req.valid) begin
               for (int i = 0; i < tmrc_pkg::RULE_SLOTS; i++) begin
                  rules_in[i] = req_rules[i];
               end
               if (req.rule_count == '0) begin
                  nrules_in = tmrc_pkg::RCNT_W'(1);
               end else if (int'(req.rule_count) > tmrc_pkg::RULE_SLOTS) begin
                  nrules_in = tmrc_pkg::RCNT_W'(tmrc_pkg::RULE_SLOTS);
               end else begin
                  nrules_in = tmrc_pkg::RCNT_W'(req.rule_count);
               end
               limit_in = (step_limit_ff == '0) ? 8'd1 : step_limit_ff;
               if (int'(start_cell_ff) > TAPE_LAST) begin
                  pos_in = tmrc_pkg::POS_W'(TAPE_LAST);
               end else begin
                  pos_in = tmrc_pkg::POS_W'(start_cell_ff);
               end
               mach_in  = '0;
               steps_in = '0;
               tape_in  = '0;
               ones_in  = '0;
               ctl_in   = S_RUN;
            end
         end
         S_RUN: begin
            tape_in[pos_ff] = action.write_sym;
            steps_in        = steps_next;
            if (offtape) begin
               status_in = tmrc_pkg::STATUS_OFFTAPE;
               ctl_in    = S_POST;
            end else begin
               pos_in = action.move_right ? pos_ff + 1'b1 : pos_ff - 1'b1;
               if (action.next_code == tmrc_pkg::HALT_CODE) begin
                  status_in = tmrc_pkg::STATUS_HALTED;
                  chunk_in  = tmrc_pkg::CHUNK_W'(tmrc_pkg::CHUNKS);
                  ctl_in    = S_COUNT;
               end else begin
                  mach_in = action.next_code[1:0];
                  if (steps_next == limit_ff) begin
                     status_in = tmrc_pkg::STATUS_LIMIT;
                     ctl_in    = S_POST;
                  end
               end
            end
         end
         S_COUNT: begin
            // The tape drains eight cells a cycle through the popcount adder.
            ones_in  = ones_ff + tmrc_pkg::ONES_W'(tmrc_pkg::popcount8(
                          tape_ff[tmrc_pkg::CHUNK_BITS-1:0]));
            tape_in  = tape_ff >> tmrc_pkg::CHUNK_BITS;
            chunk_in = chunk_ff - 1'b1;
            if (chunk_ff == tmrc_pkg::CHUNK_W'(1)) begin
               ctl_in = S_POST;
            end
         end
         S_POST: begin
            // Wait here only if the previous result has not been transferred yet.
            if (!rsp_valid_ff || rsp.ready) begin
               out_status_in = status_ff;
               out_ones_in   = ones_ff;
               out_steps_in  = steps_ff;
               rsp_valid_in  = 1'b1;
               ctl_in        = S_IDLE;
            end
         end
         default: ctl_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         step_limit_ff <= tmrc_pkg::STEP_LIMIT_RESET;
         start_cell_ff <= tmrc_pkg::START_CELL_RESET;
      end else begin
         ctl_ff        <= ctl_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_limit_ff <= step_limit_in;
         start_cell_ff <= start_cell_in;
      end
   end

   always_ff @(posedge clock) begin
      rules_ff      <= rules_in;
      nrules_ff     <= nrules_in;
      limit_ff      <= limit_in;
      pos_ff        <= pos_in;
      mach_ff       <= mach_in;
      steps_ff      <= steps_in;
      tape_ff       <= tape_in;
      ones_ff       <= ones_in;
      chunk_ff      <= chunk_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_ones_ff   <= out_ones_in;
      out_steps_ff  <= out_steps_in;
   end

endmodule

/* hdl/tmrc_rule_sel.sv */
// Priority rule matcher: picks the first rule in use that fits state and symbol.
`timescale 1ns / 1ps

module tmrc_rule_sel (
   input  tmrc_pkg::rule_array_type              rules,
   input  logic [tmrc_pkg::RCNT_W-1:0]           rule_count,
   input  logic [1:0]                            mach_state,
   input  logic                                  read_sym,
   output tmrc_pkg::rule_action_type             action
);

   tmrc_pkg::rule_type chosen;

   always_comb begin
      chosen = '0;
      // Fallback is the last rule in use.
      for (int i = 0; i < tmrc_pkg::RULE_SLOTS; i++) begin
         if (tmrc_pkg::RCNT_W'(i + 1) == rule_count) begin
            chosen = rules[i];
         end
      end
      // Walk from the top down so that the lowest matching rule wins.
      for (int i = tmrc_pkg::RULE_SLOTS - 1; i >= 0; i--) begin
         if ((tmrc_pkg::RCNT_W'(i) < rule_count) &&
             (rules[i][7:6] == mach_state) && (rules[i][5] == read_sym)) begin
            chosen = rules[i];
         end
      end
   end

   assign action.next_code  = chosen[4:2];
   assign action.write_sym  = chosen[1];
   assign action.move_right = chosen[0];

endmodule
